/* design/tpa_pkg.sv */
// Shared types and constants for triangle primitive assembly.
package tpa_pkg;

  // Assembly mode codes; the unused code behaves as a triangle list
  localparam logic [1:0] MODE_LIST  = 2'd0;
  localparam logic [1:0] MODE_STRIP = 2'd1;
  localparam logic [1:0] MODE_FAN   = 2'd2;

  // Configuration register indexes (word address)
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_VCOUNT = 2'd1;
  localparam logic [1:0] REG_BASE   = 2'd2;

  localparam int unsigned ADDR_W = 4;

  // Number of indices held before a triangle can close
  localparam logic [1:0] SEEN_FULL = 2'd2;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  assembly_mode;
    logic [31:0] vertex_count;
    logic [31:0] base_offset;
  } cfg_t;

  typedef struct packed {
    logic [31:0] local_index;
    logic        end_of_primitive;
  } in_item_t;

  typedef struct packed {
    logic [31:0] corner_a;
    logic [31:0] corner_b;
    logic [31:0] corner_c;
    logic        was_dropped;
    logic [31:0] emitted_total;
    logic [31:0] dropped_total;
  } out_item_t;

endpackage

/* design/triangle_primitive_assembly_top.sv */
// Top level of triangle primitive assembly: input register, core and result register.
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i / in_stall_o    in_item_i  (in_item_t)
//   out       output     out_valid_o / out_stall_i  out_item_o (out_item_t)
//   config    input      psel/penable/pwrite        paddr, pwdata, prdata
//
// One index transaction is accepted per cycle unless the input stalls; its triangle,
// if any, passes through the input register and then the result register.
// An output stall holds the result register and backs up into the input register;
// the input stalls only while both are full. Reset clears all sequence state,
// counters and configuration at once.
module triangle_primitive_assembly_top
  import tpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t      cfg;
  logic      in_valid_q;
  in_item_t  in_q;
  logic      advance;
  logic      accept;
  logic      tri_valid;
  out_item_t tri_item;

  tpa_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance when the result slot is free or being taken
  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
  end

  tpa_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .proc_en_i   (in_valid_q && advance),
    .item_i      (in_q),
    .tri_valid_o (tri_valid),
    .tri_o       (tri_item)
  );

  tpa_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .tri_valid_i (in_valid_q && tri_valid),
    .tri_i       (tri_item),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

/* design/tpa_cfg_regs.sv */
// APB-style configuration registers for triangle primitive assembly.
module tpa_cfg_regs
  import tpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Decode the write; indexes beyond the list are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:   cfg_d.assembly_mode = pwdata[1:0];
        REG_VCOUNT: cfg_d.vertex_count  = pwdata;
        REG_BASE:   cfg_d.base_offset   = pwdata;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_MODE:   prdata = {30'd0, cfg_q.assembly_mode};
      REG_VCOUNT: prdata = cfg_q.vertex_count;
      REG_BASE:   prdata = cfg_q.base_offset;
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* design/tpa_core.sv */
// Sequence state and triangle forming logic for triangle primitive assembly.
module tpa_core
  import tpa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      proc_en_i,
  input  in_item_t  item_i,
  output logic      tri_valid_o,
  output out_item_t tri_o
);

  logic [31:0] anchor_q, anchor_d;
  logic [31:0] older_q, older_d;
  logic [31:0] newer_q, newer_d;
  logic [1:0]  seen_q, seen_d;
  logic        odd_q, odd_d;
  logic [31:0] emit_q, emit_d;
  logic [31:0] drop_q, drop_d;

  logic [31:0] idx;
  logic [31:0] ca, cb, cc;
  logic        full;
  logic        bad;

  assign idx  = item_i.local_index;
  assign full = (seen_q == SEEN_FULL);

  // Pick the two stored corners for the current mode
  always_comb begin
    unique case (cfg_i.assembly_mode)
      MODE_STRIP: begin
        ca = odd_q ? newer_q : older_q;
        cb = odd_q ? older_q : newer_q;
      end
      MODE_FAN: begin
        ca = anchor_q;
        cb = newer_q;
      end
      default: begin
        ca = older_q;
        cb = newer_q;
      end
    endcase
    cc = idx;
  end

  assign bad = (ca >= cfg_i.vertex_count) || (cb >= cfg_i.vertex_count) ||
               (cc >= cfg_i.vertex_count);

  // Advance the sequence state and counters
  always_comb begin
    anchor_d = anchor_q;
    older_d  = older_q;
    newer_d  = newer_q;
    seen_d   = seen_q;
    odd_d    = odd_q;
    emit_d   = emit_q;
    drop_d   = drop_q;
    if (full) begin
      if (bad) begin
        if (drop_q != COUNT_MAX) drop_d = drop_q + 32'd1;
      end else begin
        if (emit_q != COUNT_MAX) emit_d = emit_q + 32'd1;
      end
    end
    unique case (cfg_i.assembly_mode)
      MODE_STRIP: begin
        if (seen_q == 2'd0) begin
          older_d = idx;
          seen_d  = 2'd1;
        end else if (seen_q == 2'd1) begin
          newer_d = idx;
          seen_d  = SEEN_FULL;
        end else begin
          older_d = newer_q;
          newer_d = idx;
          odd_d   = ~odd_q;
        end
      end
      MODE_FAN: begin
        if (seen_q == 2'd0) begin
          anchor_d = idx;
          seen_d   = 2'd1;
        end else if (seen_q == 2'd1) begin
          newer_d = idx;
          seen_d  = SEEN_FULL;
        end else begin
          newer_d = idx;
        end
      end
      default: begin
        if (seen_q == 2'd0) begin
          older_d = idx;
          seen_d  = 2'd1;
        end else if (seen_q == 2'd1) begin
          newer_d = idx;
          seen_d  = SEEN_FULL;
        end else begin
          seen_d = 2'd0;
        end
      end
    endcase
  end

  // Form the result transaction
  always_comb begin
    tri_valid_o         = full;
    tri_o.was_dropped   = bad;
    tri_o.corner_a      = bad ? 32'd0 : ca + cfg_i.base_offset;
    tri_o.corner_b      = bad ? 32'd0 : cb + cfg_i.base_offset;
    tri_o.corner_c      = bad ? 32'd0 : cc + cfg_i.base_offset;
    tri_o.emitted_total = emit_d;
    tri_o.dropped_total = drop_d;
  end

  // Hold state; clear everything after the end of a primitive
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_q <= '0;
      older_q  <= '0;
      newer_q  <= '0;
      seen_q   <= '0;
      odd_q    <= 1'b0;
      emit_q   <= '0;
      drop_q   <= '0;
    end else if (proc_en_i) begin
      if (item_i.end_of_primitive) begin
        anchor_q <= '0;
        older_q  <= '0;
        newer_q  <= '0;
        seen_q   <= '0;
        odd_q    <= 1'b0;
        emit_q   <= '0;
        drop_q   <= '0;
      end else begin
        anchor_q <= anchor_d;
        older_q  <= older_d;
        newer_q  <= newer_d;
        seen_q   <= seen_d;
        odd_q    <= odd_d;
        emit_q   <= emit_d;
        drop_q   <= drop_d;
      end
    end
  end

endmodule

/* design/tpa_out_reg.sv */
// Result register with stall for triangle primitive assembly.
module tpa_out_reg
  import tpa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  logic      tri_valid_i,
  input  out_item_t tri_i,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  logic      res_valid_q;
  out_item_t res_q;

  // Load a new slot when the stage advances, else hold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load_i) begin
      res_valid_q <= tri_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && tri_valid_i) begin
      res_q <= tri_i;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_item_o  = res_q;

endmodule
